>>> design/ucst_pkg.sv
// Shared types, constants and CORDIC table for the unicycle step and cost unit.
`default_nettype none
package ucst_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_STEP_TIME       = 3'd0,
		REG_WEIGHT_POS      = 3'd1,
		REG_WEIGHT_HEAD     = 3'd2,
		REG_WEIGHT_SPEED    = 3'd3,
		REG_WEIGHT_TURN     = 3'd4,
		REG_WEIGHT_FIN_POS  = 3'd5,
		REG_WEIGHT_FIN_HEAD = 3'd6
	} reg_idx_t;

	localparam logic [15:0] STEP_TIME_RST = 16'd6554;
	localparam logic [15:0] WEIGHT_RST    = 16'd256;

	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [29:0] INV_PI_Q30  = 30'sd341782638;
	localparam logic signed [18:0] PI_Q16      = 19'sd205887;
	localparam logic [47:0]        CAP48       = 48'hFFFF_FFFF_FFFF;
	localparam int                 TABLE_LEN   = 24;

	// arctangent of 2^-i, 2^32 per turn
	localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81};

	// configuration register file contents
	typedef struct packed {
		logic [15:0] step_time;
		logic [15:0] weight_position;
		logic [15:0] weight_heading;
		logic [15:0] weight_speed;
		logic [15:0] weight_turn;
		logic [15:0] weight_final_position;
		logic [15:0] weight_final_heading;
	} cfg_t;

	// operands that ride along the rotation stages
	typedef struct packed {
		logic               terminal;
		logic               flip;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [15:0]        hd;
		logic signed [15:0] v;
		logic signed [15:0] w;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [34:0] ehp;
		logic signed [32:0] dtv;
		logic signed [32:0] dtw;
	} item_t;

	// arctangent of stage idx rounded to an ab-bit angle
	function automatic logic [31:0] atan_angle(input int unsigned idx, input int unsigned ab);
		logic [32:0] t;
		t = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (31 - ab));
		return 32'(t >> (32 - ab));
	endfunction

endpackage
`default_nettype wire

>>> design/ucst_front.sv
// Input stage: errors, step products and CORDIC angle fold.
`default_nettype none
module ucst_front #(
	parameter int ANGLE_BITS = 16,
	parameter int ZW = 18
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire ucst_pkg::cfg_t     cfg,
	input  wire logic               operation,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [15:0] heading,
	input  wire logic signed [15:0] speed,
	input  wire logic signed [15:0] turn_rate,
	input  wire logic signed [31:0] ref_x,
	input  wire logic signed [31:0] ref_y,
	input  wire logic signed [15:0] ref_heading,
	output ucst_pkg::item_t         item_s1,
	output logic signed [32:0]      x_s1,
	output logic signed [32:0]      y_s1,
	output logic signed [ZW-1:0]    z_s1
);
	import ucst_pkg::*;

	localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1 << (ANGLE_BITS - 2));
	localparam logic signed [ZW-1:0] HALF    = ZW'(64'sd1 << (ANGLE_BITS - 1));

	item_t               item_c;
	logic signed [15:0]  dh_c;
	logic [31:0]         zfull_c;
	logic signed [ZW-1:0] zi_c;
	logic signed [ZW-1:0] z_c;

	// operands and folded angle
	always_comb begin
		dh_c            = heading - ref_heading;
		item_c.terminal = operation;
		item_c.px       = pos_x;
		item_c.py       = pos_y;
		item_c.hd       = heading;
		item_c.v        = speed;
		item_c.w        = turn_rate;
		item_c.dx       = {pos_x[31], pos_x} - {ref_x[31], ref_x};
		item_c.dy       = {pos_y[31], pos_y} - {ref_y[31], ref_y};
		item_c.ehp      = dh_c * PI_Q16;
		item_c.dtv      = $signed({1'b0, cfg.step_time}) * speed;
		item_c.dtw      = $signed({1'b0, cfg.step_time}) * turn_rate;
		zfull_c = {heading, 16'h0000} >> (32 - ANGLE_BITS);
		zi_c    = {{(ZW - ANGLE_BITS){zfull_c[ANGLE_BITS-1]}}, zfull_c[ANGLE_BITS-1:0]};
		if (zi_c > QUARTER) begin
			z_c         = zi_c - HALF;
			item_c.flip = 1'b1;
		end else if (zi_c < -QUARTER) begin
			z_c         = zi_c + HALF;
			item_c.flip = 1'b1;
		end else begin
			z_c         = zi_c;
			item_c.flip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_c;
			x_s1    <= CORDIC_GAIN;
			y_s1    <= '0;
			z_s1    <= z_c;
		end
	end

endmodule
`default_nettype wire

>>> design/ucst_cordic_stage.sv
// One CORDIC rotation stage with its carried operands.
`default_nettype none
module ucst_cordic_stage #(
	parameter int ANGLE_BITS = 16,
	parameter int ZW = 18,
	parameter int INDEX = 0
) (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire ucst_pkg::item_t     item_in,
	input  wire logic signed [32:0]  x_in,
	input  wire logic signed [32:0]  y_in,
	input  wire logic signed [ZW-1:0] z_in,
	output ucst_pkg::item_t          item_s1,
	output logic signed [32:0]       x_s1,
	output logic signed [32:0]       y_s1,
	output logic signed [ZW-1:0]     z_s1
);
	import ucst_pkg::*;

	localparam logic signed [ZW-1:0] ANG = ZW'(atan_angle(INDEX, ANGLE_BITS));

	logic signed [32:0] xs_c;
	logic signed [32:0] ys_c;

	assign xs_c = y_in >>> INDEX;
	assign ys_c = x_in >>> INDEX;

	// rotate toward zero residual; zero rotates positive
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_in;
			if (!z_in[ZW-1]) begin
				x_s1 <= x_in - xs_c;
				y_s1 <= y_in + ys_c;
				z_s1 <= z_in - ANG;
			end else begin
				x_s1 <= x_in + xs_c;
				y_s1 <= y_in - ys_c;
				z_s1 <= z_in + ANG;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/ucst_back.sv
// Pose update, cost terms and gradients over four stages.
`default_nettype none
module ucst_back (
	input  wire logic               clk,
	input  wire logic [3:0]         en,
	input  wire ucst_pkg::cfg_t     cfg,
	input  wire ucst_pkg::item_t    item_in,
	input  wire logic signed [32:0] x_in,
	input  wire logic signed [32:0] y_in,
	output logic signed [31:0]      next_x,
	output logic signed [31:0]      next_y,
	output logic signed [15:0]      next_heading,
	output logic [47:0]             cost,
	output logic signed [47:0]      grad_x,
	output logic signed [47:0]      grad_y,
	output logic signed [47:0]      grad_heading,
	output logic signed [47:0]      grad_speed,
	output logic signed [47:0]      grad_turn
);
	import ucst_pkg::*;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] s);
		if (s > 34'sd2147483647) return 32'sh7FFF_FFFF;
		if (s < -34'sd2147483648) return 32'sh8000_0000;
		return s[31:0];
	endfunction

	// weight a Q16 square, truncate to Q16 and cap
	function automatic logic [47:0] wsat(input logic [48:0] sq, input logic [15:0] wt);
		logic [64:0] p;
		p = sq * wt;
		if (p[64:56] != '0) return CAP48;
		return p[55:8];
	endfunction

	// stage one: products
	logic signed [32:0] c_c, s_c, adx_c, ady_c;
	logic               term_s1;
	logic signed [31:0] px_s1, py_s1;
	logic [15:0]        hd_s1, wh_s1;
	logic signed [65:0] pcx_s1, pcy_s1;
	logic signed [62:0] phd_s1;
	logic signed [16:0] e_s1;
	logic [63:0]        asqx_s1, asqy_s1;
	logic signed [31:0] vv_s1, ww_s1;
	logic signed [49:0] gxp_s1, gyp_s1;
	logic signed [32:0] gsp_s1, gtp_s1;
	logic [15:0]        wp_c, wh_c;

	always_comb begin
		c_c   = item_in.flip ? -x_in : x_in;
		s_c   = item_in.flip ? -y_in : y_in;
		adx_c = item_in.dx[32] ? -item_in.dx : item_in.dx;
		ady_c = item_in.dy[32] ? -item_in.dy : item_in.dy;
		wp_c  = item_in.terminal ? cfg.weight_final_position : cfg.weight_position;
		wh_c  = item_in.terminal ? cfg.weight_final_heading : cfg.weight_heading;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			term_s1 <= item_in.terminal;
			px_s1   <= item_in.px;
			py_s1   <= item_in.py;
			hd_s1   <= item_in.hd;
			wh_s1   <= wh_c;
			pcx_s1  <= item_in.dtv * c_c;
			pcy_s1  <= item_in.dtv * s_c;
			phd_s1  <= item_in.dtw * INV_PI_Q30;
			e_s1    <= 17'((item_in.ehp + 35'sd131072) >>> 18);
			asqx_s1 <= adx_c[31:0] * adx_c[31:0];
			asqy_s1 <= ady_c[31:0] * ady_c[31:0];
			vv_s1   <= item_in.v * item_in.v;
			ww_s1   <= item_in.w * item_in.w;
			gxp_s1  <= $signed({1'b0, wp_c}) * item_in.dx;
			gyp_s1  <= $signed({1'b0, wp_c}) * item_in.dy;
			gsp_s1  <= $signed({1'b0, cfg.weight_speed}) * item_in.v;
			gtp_s1  <= $signed({1'b0, cfg.weight_turn}) * item_in.w;
		end
	end

	// stage two: pose sums, error square, gradient shifts
	logic signed [27:0] rx_c, ry_c;
	logic signed [62:0] hr_c;
	logic signed [33:0] ee_c;
	logic signed [33:0] ghp_c;
	logic               term_s2;
	logic [15:0]        wp_s2, wh_s2;
	logic signed [31:0] nx_s2, ny_s2;
	logic [15:0]        nh_s2;
	logic [48:0]        psq_s2;
	logic [23:0]        esq_s2;
	logic [30:0]        vsq_s2, wsq_s2;
	logic signed [47:0] gx_s2, gy_s2, gh_s2, gs_s2, gt_s2;

	always_comb begin
		rx_c  = 28'((pcx_s1 + (66'sd1 <<< 37)) >>> 38);
		ry_c  = 28'((pcy_s1 + (66'sd1 <<< 37)) >>> 38);
		hr_c  = (phd_s1 + (63'sd1 <<< 38)) >>> 39;
		ee_c  = e_s1 * e_s1;
		ghp_c = $signed({1'b0, wh_s1}) * e_s1;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			term_s2 <= term_s1;
			wh_s2   <= wh_s1;
			wp_s2   <= '0;
			psq_s2  <= 49'(asqx_s1 >> 16) + 49'(asqy_s1 >> 16);
			esq_s2  <= ee_c[33:10];
			vsq_s2  <= vv_s1[30:0];
			wsq_s2  <= ww_s1[30:0];
			gx_s2   <= 48'(gxp_s1 >>> 7);
			gy_s2   <= 48'(gyp_s1 >>> 7);
			gh_s2   <= 48'(ghp_c >>> 4);
			if (term_s1) begin
				nx_s2 <= px_s1;
				ny_s2 <= py_s1;
				nh_s2 <= hd_s1;
				gs_s2 <= '0;
				gt_s2 <= '0;
			end else begin
				nx_s2 <= sat32(34'(px_s1) + 34'(rx_c));
				ny_s2 <= sat32(34'(py_s1) + 34'(ry_c));
				nh_s2 <= hd_s1 + hr_c[15:0];
				gs_s2 <= 48'(gsp_s1) <<< 1;
				gt_s2 <= 48'(gtp_s1) <<< 1;
			end
		end
	end

	// stage three: weighted terms (position weight re-selected from config)
	logic [47:0]        tp_s3, th_s3, tv_s3, tt_s3;
	logic signed [31:0] nx_s3, ny_s3;
	logic [15:0]        nh_s3;
	logic signed [47:0] gx_s3, gy_s3, gh_s3, gs_s3, gt_s3;
	logic [15:0]        wpos_c;

	assign wpos_c = term_s2 ? cfg.weight_final_position : cfg.weight_position;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			tp_s3 <= wsat(psq_s2, wpos_c | wp_s2);
			th_s3 <= wsat(49'(esq_s2), wh_s2);
			tv_s3 <= term_s2 ? '0 : wsat(49'(vsq_s2), cfg.weight_speed);
			tt_s3 <= term_s2 ? '0 : wsat(49'(wsq_s2), cfg.weight_turn);
			nx_s3 <= nx_s2;
			ny_s3 <= ny_s2;
			nh_s3 <= nh_s2;
			gx_s3 <= gx_s2;
			gy_s3 <= gy_s2;
			gh_s3 <= gh_s2;
			gs_s3 <= gs_s2;
			gt_s3 <= gt_s2;
		end
	end

	// stage four: cost sum with cap, output register
	logic [49:0] sum_c;

	assign sum_c = 50'(tp_s3) + 50'(th_s3) + 50'(tv_s3) + 50'(tt_s3);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			cost         <= (sum_c[49:48] != 2'b00) ? CAP48 : sum_c[47:0];
			next_x       <= nx_s3;
			next_y       <= ny_s3;
			next_heading <= nh_s3;
			grad_x       <= gx_s3;
			grad_y       <= gy_s3;
			grad_heading <= gh_s3;
			grad_speed   <= gs_s3;
			grad_turn    <= gt_s3;
		end
	end

endmodule
`default_nettype wire

>>> design/unicycle_step_and_tracking_cost_unit.sv
// Top level: config registers, stage valid chain, front, CORDIC stages and back end.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_stall, 9 fields      | word in
//  out     | out_valid, out_stall, 9 fields    | word out
//  cfg     | cfg_write, cfg_index, cfg_data    | write only
//
// One word per cycle while in_stall is low; the pipeline is an input stage, one stage
// per CORDIC rotation and four stages of multiply, sum and saturate.
// Reset clears all valid bits and loads the register reset values.
// A stall holds only the occupied stages at the tail; bubbles ahead still fill,
// so in_stall rises only when every stage holds a word.
`default_nettype none
module unicycle_step_and_tracking_cost_unit #(
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               operation,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [15:0] heading,
	input  wire logic signed [15:0] speed,
	input  wire logic signed [15:0] turn_rate,
	input  wire logic signed [31:0] ref_x,
	input  wire logic signed [31:0] ref_y,
	input  wire logic signed [15:0] ref_heading,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      next_x,
	output logic signed [31:0]      next_y,
	output logic signed [15:0]      next_heading,
	output logic [47:0]             cost,
	output logic signed [47:0]      grad_x,
	output logic signed [47:0]      grad_y,
	output logic signed [47:0]      grad_heading,
	output logic signed [47:0]      grad_speed,
	output logic signed [47:0]      grad_turn
);
	import ucst_pkg::*;

	localparam int ZW = ANGLE_BITS + 2;
	localparam int L  = CORDIC_STAGES + 5;

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_time             <= STEP_TIME_RST;
			cfg_q.weight_position       <= WEIGHT_RST;
			cfg_q.weight_heading        <= WEIGHT_RST;
			cfg_q.weight_speed          <= WEIGHT_RST;
			cfg_q.weight_turn           <= WEIGHT_RST;
			cfg_q.weight_final_position <= WEIGHT_RST;
			cfg_q.weight_final_heading  <= WEIGHT_RST;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_STEP_TIME:       cfg_q.step_time             <= cfg_data;
				REG_WEIGHT_POS:      cfg_q.weight_position       <= cfg_data;
				REG_WEIGHT_HEAD:     cfg_q.weight_heading        <= cfg_data;
				REG_WEIGHT_SPEED:    cfg_q.weight_speed          <= cfg_data;
				REG_WEIGHT_TURN:     cfg_q.weight_turn           <= cfg_data;
				REG_WEIGHT_FIN_POS:  cfg_q.weight_final_position <= cfg_data;
				REG_WEIGHT_FIN_HEAD: cfg_q.weight_final_heading  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valid bits; a stage holds when out_stall is high and it and everything after it is full
	logic [L-1:0] v_q;
	logic [L-1:0] en;

	always_comb begin
		for (int k = 0; k < L; k++) begin
			en[k] = !(out_stall && (&((v_q >> k) | ~({L{1'b1}} >> k))));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 0; k < L; k++) begin
				if (en[k]) v_q[k] <= (k == 0) ? in_valid : v_q[(k == 0) ? 0 : k - 1];
			end
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = v_q[L-1];

	// datapath
	item_t               item_p [CORDIC_STAGES+1];
	logic signed [32:0]  x_p    [CORDIC_STAGES+1];
	logic signed [32:0]  y_p    [CORDIC_STAGES+1];
	logic signed [ZW-1:0] z_p   [CORDIC_STAGES+1];

	ucst_front #(.ANGLE_BITS(ANGLE_BITS), .ZW(ZW)) u_front (
		.clk(clk), .en(en[0]), .cfg(cfg_q),
		.operation(operation), .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
		.speed(speed), .turn_rate(turn_rate), .ref_x(ref_x), .ref_y(ref_y),
		.ref_heading(ref_heading),
		.item_s1(item_p[0]), .x_s1(x_p[0]), .y_s1(y_p[0]), .z_s1(z_p[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		ucst_cordic_stage #(.ANGLE_BITS(ANGLE_BITS), .ZW(ZW), .INDEX(i)) u_stage (
			.clk(clk), .en(en[i+1]),
			.item_in(item_p[i]), .x_in(x_p[i]), .y_in(y_p[i]), .z_in(z_p[i]),
			.item_s1(item_p[i+1]), .x_s1(x_p[i+1]), .y_s1(y_p[i+1]), .z_s1(z_p[i+1])
		);
	end

	ucst_back u_back (
		.clk(clk), .en(en[L-1:L-4]), .cfg(cfg_q),
		.item_in(item_p[CORDIC_STAGES]), .x_in(x_p[CORDIC_STAGES]),
		.y_in(y_p[CORDIC_STAGES]),
		.next_x(next_x), .next_y(next_y), .next_heading(next_heading), .cost(cost),
		.grad_x(grad_x), .grad_y(grad_y), .grad_heading(grad_heading),
		.grad_speed(grad_speed), .grad_turn(grad_turn)
	);

	// checks
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_q[0] && out_valid))
		else $error("input stalled with an empty stage");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_q[0])
		else $error("accepted word not in first stage");

	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_stall && v_q[L-1] && v_q[L-2]) |-> !en[L-2])
		else $error("full tail advanced under stall");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_stall) |-> (&en))
		else $error("stage held without output stall");

endmodule
`default_nettype wire

>>> tb/sv/tb_unicycle_step_and_tracking_cost_unit.sv
// Testbench for the unicycle step and tracking cost unit: predictor, stimulus and checks.
`timescale 1ns / 1ps
module tb_unicycle_step_and_tracking_cost_unit;
	import ucst_pkg::*;

	localparam logic [2:0] IDX_UNUSED = 3'd7;
	localparam int DRAIN_CYCLES = 40;

	// one input word and one result word
	typedef struct {
		logic               op;
		logic signed [31:0] px, py, rx, ry;
		logic signed [15:0] hd, v, w, rh;
	} robot_word_t;

	typedef struct {
		logic [31:0] nx, ny;
		logic [15:0] nh;
		logic [47:0] cost, gx, gy, gh, gs, gt;
	} pose_cost_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = 1'b0;
	logic signed [31:0] pos_x = '0, pos_y = '0, ref_x = '0, ref_y = '0;
	logic signed [15:0] heading = '0, speed = '0, turn_rate = '0, ref_heading = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] next_x, next_y;
	logic signed [15:0] next_heading;
	logic [47:0] cost;
	logic signed [47:0] grad_x, grad_y, grad_heading, grad_speed, grad_turn;

	// predictor copy of the register file
	cfg_t regs;
	pose_cost_t pending_results[$];
	int errors = 0;
	bit in_idle = 1'b1;
	bit out_idle = 1'b1;
	int stall_left = 0;

	unicycle_step_and_tracking_cost_unit DUT (.*);

	always #5 clk = ~clk;

	function automatic logic [47:0] sat48(longint val);
		if (val > 64'sd140737488355327) return 48'h7FFF_FFFF_FFFF;
		if (val < -64'sd140737488355328) return 48'h8000_0000_0000;
		return val[47:0];
	endfunction

	function automatic logic [31:0] sat32(longint val);
		if (val > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (val < -64'sd2147483648) return 32'h8000_0000;
		return val[31:0];
	endfunction

	// squared term in Q16 times Q8.8 weight, capped at 48 bits
	function automatic logic [63:0] weigh_square(logic [63:0] sq, logic [15:0] wt);
		logic [79:0] p;
		p = (80'(sq) * 80'(wt)) >> 8;
		return (p > 80'(CAP48)) ? 64'(CAP48) : p[63:0];
	endfunction

	function automatic pose_cost_t predict_pose_cost(robot_word_t it);
		pose_cost_t r;
		longint dx, dy, dh, e, v, w, dtv, dtw, z, xr, yr, xs, ys, a, c, s;
		logic signed [15:0] dh16;
		logic [63:0] adx, ady, psq, total;
		logic [15:0] wp, wh;
		bit flip;
		wp = it.op ? regs.weight_final_position : regs.weight_position;
		wh = it.op ? regs.weight_final_heading : regs.weight_heading;
		dx = longint'(it.px) - longint'(it.rx);
		dy = longint'(it.py) - longint'(it.ry);
		dh16 = it.hd - it.rh;
		dh = dh16;
		e = (dh * longint'(PI_Q16) + (64'sd1 <<< 17)) >>> 18;
		adx = (dx < 0) ? -dx : dx;
		ady = (dy < 0) ? -dy : dy;
		psq = ((adx * adx) >> 16) + ((ady * ady) >> 16);
		total = weigh_square(psq, wp) + weigh_square(64'(e * e) >> 10, wh);
		r.nx = it.px;
		r.ny = it.py;
		r.nh = it.hd;
		r.gs = '0;
		r.gt = '0;
		if (!it.op) begin
			v = it.v;
			w = it.w;
			dtv = longint'(regs.step_time) * v;
			dtw = longint'(regs.step_time) * w;
			// fold into the right half plane, then rotate
			z = longint'($unsigned(it.hd));
			if (z >= 32768) z -= 65536;
			flip = 1'b0;
			if (z > 16384) begin
				z -= 32768;
				flip = 1'b1;
			end else if (z < -16384) begin
				z += 32768;
				flip = 1'b1;
			end
			xr = CORDIC_GAIN;
			yr = 0;
			for (int i = 0; i < 16; i++) begin
				a = (longint'(ATAN_TURN32[i]) + 32768) >> 16;
				xs = yr >>> i;
				ys = xr >>> i;
				if (z >= 0) begin
					xr -= xs;
					yr += ys;
					z -= a;
				end else begin
					xr += xs;
					yr -= ys;
					z += a;
				end
			end
			c = flip ? -xr : xr;
			s = flip ? -yr : yr;
			r.nx = sat32(longint'(it.px) + ((dtv * c + (64'sd1 <<< 37)) >>> 38));
			r.ny = sat32(longint'(it.py) + ((dtv * s + (64'sd1 <<< 37)) >>> 38));
			r.nh = it.hd + 16'((dtw * longint'(INV_PI_Q30) + (64'sd1 <<< 38)) >>> 39);
			total += weigh_square(64'(v * v), regs.weight_speed);
			total += weigh_square(64'(w * w), regs.weight_turn);
			r.gs = sat48(2 * longint'(regs.weight_speed) * v);
			r.gt = sat48(2 * longint'(regs.weight_turn) * w);
		end
		r.cost = (total > 64'(CAP48)) ? CAP48 : total[47:0];
		r.gx = sat48((longint'(wp) * dx) >>> 7);
		r.gy = sat48((longint'(wp) * dy) >>> 7);
		r.gh = sat48((longint'(wh) * e) >>> 4);
		return r;
	endfunction

	task automatic check_field(string name, logic [47:0] exp_val, logic [47:0] act_val);
		if (exp_val !== act_val) begin
			errors++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
		end
	endtask

	// result checker and receiver stall
	always @(posedge clk) begin
		pose_cost_t exp_r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result word with nothing expected, expected none, actual cost %h",
						$time, cost);
				end else begin
					exp_r = pending_results.pop_front();
					check_field("next_x", 48'(exp_r.nx), 48'($unsigned(next_x)));
					check_field("next_y", 48'(exp_r.ny), 48'($unsigned(next_y)));
					check_field("next_heading", 48'(exp_r.nh),
						48'($unsigned(next_heading)));
					check_field("cost", exp_r.cost, cost);
					check_field("grad_x", exp_r.gx, grad_x);
					check_field("grad_y", exp_r.gy, grad_y);
					check_field("grad_heading", exp_r.gh, grad_heading);
					check_field("grad_speed", exp_r.gs, grad_speed);
					check_field("grad_turn", exp_r.gt, grad_turn);
				end
				stall_left = out_idle ? $urandom_range(0, 11) : 0;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// send one word, keep valid high into the next word when there is no gap
	task automatic send_word(robot_word_t it);
		int gap;
		operation <= it.op;
		pos_x <= it.px;
		pos_y <= it.py;
		heading <= it.hd;
		speed <= it.v;
		turn_rate <= it.w;
		ref_x <= it.rx;
		ref_y <= it.ry;
		ref_heading <= it.rh;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(predict_pose_cost(it));
		gap = in_idle ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_STEP_TIME:       regs.step_time = val;
			REG_WEIGHT_POS:      regs.weight_position = val;
			REG_WEIGHT_HEAD:     regs.weight_heading = val;
			REG_WEIGHT_SPEED:    regs.weight_speed = val;
			REG_WEIGHT_TURN:     regs.weight_turn = val;
			REG_WEIGHT_FIN_POS:  regs.weight_final_position = val;
			REG_WEIGHT_FIN_HEAD: regs.weight_final_heading = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// random word: mostly a reference near the pose so cost stays in range
	function automatic robot_word_t random_word();
		robot_word_t it;
		it.op = $urandom_range(0, 3) == 0;
		it.px = $urandom;
		it.py = $urandom;
		it.hd = 16'($urandom);
		it.v = 16'($urandom);
		it.w = 16'($urandom);
		it.rh = 16'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			it.rx = $urandom;
			it.ry = $urandom;
		end else begin
			it.rx = it.px + $signed(32'($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
			it.ry = it.py + $signed(32'($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
		end
		if ($urandom_range(0, 2) == 0) begin
			it.v = $signed(16'($urandom_range(0, 1023)) - 16'sd512);
			it.w = $signed(16'($urandom_range(0, 1023)) - 16'sd512);
		end
		return it;
	endfunction

	task automatic test_directed();
		robot_word_t it;
		// all zero, both operations
		it = '{1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
		send_word(it);
		it.op = 1'b1;
		send_word(it);
		// largest position error both ways, saturating steps
		it = '{1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
			16'sh0000, 16'sh7FFF, 16'sh7FFF, 16'sh8000};
		send_word(it);
		it = '{1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
			16'sh4000, 16'sh8000, 16'sh8000, 16'sh4000};
		send_word(it);
		it.op = 1'b1;
		send_word(it);
		// heading error of half a turn, headings at each eighth of a turn
		for (int q = 0; q < 8; q++) begin
			it = '{1'b0, 32'sh0001_0000, -32'sh0001_0000, 32'sd0, 32'sd0,
				16'(q * 8192), 16'sh0100, 16'sh0100, 16'(q * 8192 + 32768)};
			send_word(it);
		end
		it.hd = 16'sh7FFF;
		it.rh = 16'sh8000;
		send_word(it);
		it.hd = 16'sh8000;
		it.rh = 16'sh7FFF;
		send_word(it);
		drain_pipe();
	endtask

	task automatic run_random(int n);
		for (int k = 0; k < n; k++) send_word(random_word());
		drain_pipe();
	endtask

	task automatic test_config_sweep();
		robot_word_t it;
		// zero step time echoes the pose
		write_reg(REG_STEP_TIME, 16'd0);
		run_random(15);
		// all registers at the top
		write_reg(REG_STEP_TIME, 16'hFFFF);
		write_reg(REG_WEIGHT_POS, 16'hFFFF);
		write_reg(REG_WEIGHT_HEAD, 16'hFFFF);
		write_reg(REG_WEIGHT_SPEED, 16'hFFFF);
		write_reg(REG_WEIGHT_TURN, 16'hFFFF);
		write_reg(REG_WEIGHT_FIN_POS, 16'hFFFF);
		write_reg(REG_WEIGHT_FIN_HEAD, 16'hFFFF);
		it = '{1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
			16'sh2000, 16'sh7FFF, 16'sh8000, 16'sh8000};
		send_word(it);
		it.op = 1'b1;
		send_word(it);
		run_random(30);
		// weights at zero, smallest step; write to an unused index is ignored
		write_reg(REG_STEP_TIME, 16'd1);
		write_reg(REG_WEIGHT_POS, 16'd0);
		write_reg(REG_WEIGHT_HEAD, 16'd0);
		write_reg(REG_WEIGHT_SPEED, 16'd0);
		write_reg(REG_WEIGHT_TURN, 16'd0);
		write_reg(REG_WEIGHT_FIN_POS, 16'd0);
		write_reg(REG_WEIGHT_FIN_HEAD, 16'd0);
		write_reg(IDX_UNUSED, 16'hA5A5);
		run_random(30);
	endtask

	task automatic test_random();
		logic [2:0] idx;
		for (int phase = 0; phase < 10; phase++) begin
			for (int r = 0; r < 7; r++) begin
				idx = 3'(r);
				write_reg(idx, $urandom_range(0, 3) == 0 ? 16'($urandom) :
					16'($urandom_range(1, 2048)));
			end
			// some phases run back to back on the input side, others on the output side
			in_idle = (phase % 3) != 1;
			out_idle = (phase % 3) != 2;
			run_random(50);
		end
		in_idle = 1'b1;
		out_idle = 1'b1;
	endtask

	initial begin
		regs = '{STEP_TIME_RST, WEIGHT_RST, WEIGHT_RST, WEIGHT_RST, WEIGHT_RST,
			WEIGHT_RST, WEIGHT_RST};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_random();
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// run limit
	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
